FILE: rtl/core/lrs_pkg.sv
package lrs_pkg;

    // Default widths
    localparam int ITER_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF = 28;

    // Edges from an accepting edge to the edge that samples its result strobe
    localparam int LRS_LATENCY = 112;

    // Policy codes; codes six and seven fall back to fixed
    typedef enum logic [2:0] {
        POL_FIXED = 3'd0,
        POL_STEP  = 3'd1,
        POL_EXP   = 3'd2,
        POL_INV   = 3'd3,
        POL_DECAY = 3'd4,
        POL_POLY  = 3'd5
    } t_policy;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_POLICY = 3'd0,
        REG_BASE   = 3'd1,
        REG_GAMMA  = 3'd2,
        REG_POWER  = 3'd3,
        REG_STEP   = 3'd4,
        REG_DECAY  = 3'd5,
        REG_FINAL  = 3'd6
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [2:0]  RST_POLICY = POL_DECAY;
    localparam logic [31:0] RST_BASE   = 32'd2684355;
    localparam logic [31:0] RST_GAMMA  = 32'd26843546;
    localparam logic [31:0] RST_POWER  = 32'd268435456;
    localparam logic [31:0] RST_STEP   = 32'd100000;
    localparam logic [31:0] RST_DECAY  = 32'd2147;
    localparam logic [31:0] RST_FINAL  = 32'd100000;

    // Integer square root, used only to build constants
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (b > v) b = b >> 2;
        end
        for (int s = 0; s < 32; s++) begin
            if (b != 64'd0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-idx) in Q1.31, by repeated square roots of two
    function automatic logic [31:0] root_entry(input int idx);
        logic [63:0] v;
        v = 64'd1 << 32;
        for (int j = 1; j <= 32; j++) begin
            if (j <= idx) v = isqrt64(v << 31);
        end
        return v[31:0];
    endfunction

endpackage

FILE: rtl/core/learning_rate_schedule.sv
// Learning-rate schedule: returns the rate for one iteration index under
// the configured policy (fixed, step, exp, inv, decay or poly).
// Input: a transaction is taken on each rising edge with start high and busy
// low; busy stays low, so an iteration may be offered on every cycle.
// Configuration: write transactions on i_cfg_valid/o_cfg_ready carry a
// register index and data; ready stays high. Write only while no iteration
// is in flight.
// Output: o_valid is high for one cycle with o_rate_out and o_clamped. The
// results of accepted transactions come out one result per cycle, in order.
// Throughput is one iteration per cycle. The pipeline holds the divider (one
// quotient bit per stage, 33 stages), the log2 unit (one squaring multiply
// per fraction bit, 32 stages) and the exp2 unit (one table multiply per
// fraction bit, 32 stages), plus the operand, multiply and scaling stages.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults. The receiver cannot stall; results are never held.
module learning_rate_schedule
    import lrs_pkg::*;
#(
    parameter int ITER_BITS = ITER_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ITER_BITS-1:0] i_iteration,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_valid,
    output logic [31:0]          o_rate_out,
    output logic                 o_clamped
);

    localparam int Q_W   = (ITER_BITS > 33) ? ITER_BITS : 33;
    localparam int YI_W  = (ITER_BITS > 32 - FRAC_BITS) ? ITER_BITS : 32 - FRAC_BITS;
    localparam int YF_W  = FRAC_BITS;
    localparam int GI_W  = 32 + ITER_BITS;
    localparam int DT_W  = ITER_BITS + GI_W + 1;
    localparam int PT_W  = 34;
    localparam logic [64:0] ONE_Q32 = 65'd1 << 32;
    localparam logic [64:0] ONE_QF  = 65'd1 << FRAC_BITS;

    // ---------------- configuration registers
    logic [2:0]           r_policy;
    logic [31:0]          r_base;
    logic [31:0]          r_gamma;
    logic [31:0]          r_power;
    logic [ITER_BITS-1:0] r_step;
    logic [31:0]          r_decay;
    logic [ITER_BITS-1:0] r_final;

    assign o_cfg_ready = 1'b1;
    // pipeline takes a transaction every cycle
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= RST_POLICY;
            r_base   <= RST_BASE;
            r_gamma  <= RST_GAMMA;
            r_power  <= RST_POWER;
            r_step   <= RST_STEP[ITER_BITS-1:0];
            r_decay  <= RST_DECAY;
            r_final  <= RST_FINAL[ITER_BITS-1:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_POLICY: r_policy <= i_cfg_data[2:0];
                REG_BASE:   r_base   <= i_cfg_data;
                REG_GAMMA:  r_gamma  <= i_cfg_data;
                REG_POWER:  r_power  <= i_cfg_data;
                REG_STEP:   r_step   <= i_cfg_data[ITER_BITS-1:0];
                REG_DECAY:  r_decay  <= i_cfg_data;
                REG_FINAL:  r_final  <= i_cfg_data[ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- T0: capture the transaction
    logic                 r0_v;
    logic [ITER_BITS-1:0] r0_it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start && !busy;
        end
        r0_it <= i_iteration;
    end

    // ---------------- T1: gamma*iter and iter*decay
    logic                 r1_v;
    logic [ITER_BITS-1:0] r1_it;
    logic [GI_W-1:0]      r1_gi;
    logic [GI_W-1:0]      r1_di;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
        r1_it <= r0_it;
        r1_gi <= GI_W'(r_gamma) * GI_W'(r0_it);
        r1_di <= GI_W'(r0_it) * GI_W'(r_decay);
    end

    // ---------------- T2: divider operands per policy
    logic [ITER_BITS-1:0] n2_dstep;
    logic [ITER_BITS-1:0] n2_dfin;
    logic                 n2_over;
    logic [64:0]          n2_dsum;
    logic [63:0]          n2_num;
    logic [63:0]          n2_den;

    always_comb begin
        n2_dstep = (r_step == '0) ? ITER_BITS'(1) : r_step;
        n2_dfin  = (r_final == '0) ? ITER_BITS'(1) : r_final;
        n2_over  = r1_it > n2_dfin;
        n2_dsum  = 65'(r1_di) + ONE_Q32;
        case (r_policy)
            POL_STEP: begin
                n2_num = 64'(r1_it);
                n2_den = 64'(n2_dstep);
            end
            POL_DECAY: begin
                n2_num = {r_base, 32'd0};
                n2_den = n2_dsum[64] ? '1 : n2_dsum[63:0];
            end
            POL_POLY: begin
                n2_num = n2_over ? 64'd0 : (64'(n2_dfin - r1_it) << 32);
                n2_den = 64'(n2_dfin);
            end
            default: begin
                n2_num = '0;
                n2_den = 64'd1;
            end
        endcase
    end

    logic            r2_v;
    logic [63:0]     r2_num;
    logic [63:0]     r2_den;
    logic [DT_W-1:0] r2_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_num <= n2_num;
        r2_den <= n2_den;
        r2_tag <= {r1_it, r1_gi, n2_over};
    end

    logic            d_v;
    logic [Q_W-1:0]  d_quo;
    logic [DT_W-1:0] d_tag;

    lrs_div #(
        .Q_W   (Q_W),
        .TAG_W (DT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (r2_v),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_tag   (r2_tag),
        .o_v     (d_v),
        .o_quo   (d_quo),
        .o_tag   (d_tag)
    );

    // ---------------- T3: power operands per policy
    logic [ITER_BITS-1:0] n3_it;
    logic [GI_W-1:0]      n3_gi;
    logic                 n3_over;
    logic [64:0]          n3_isum;
    logic [63:0]          n3_x;
    logic [5:0]           n3_xfrac;
    logic                 n3_negy;
    logic [YI_W-1:0]      n3_yi;
    logic [YF_W-1:0]      n3_yf;
    logic                 n3_pen;
    logic                 n3_sat0;
    logic [31:0]          n3_direct;

    always_comb begin
        {n3_it, n3_gi, n3_over} = d_tag;
        n3_isum   = 65'(n3_gi) + ONE_QF;
        n3_x      = 64'(r_gamma);
        n3_xfrac  = 6'(FRAC_BITS);
        n3_negy   = 1'b0;
        n3_yi     = '0;
        n3_yf     = '0;
        n3_pen    = 1'b0;
        n3_sat0   = 1'b0;
        n3_direct = r_base;
        case (r_policy)
            POL_STEP: begin
                n3_pen = 1'b1;
                n3_yi  = d_quo[YI_W-1:0];
            end
            POL_EXP: begin
                n3_pen = 1'b1;
                n3_yi  = YI_W'(n3_it);
            end
            POL_INV: begin
                n3_pen  = 1'b1;
                n3_x    = n3_isum[64] ? '1 : n3_isum[63:0];
                n3_negy = 1'b1;
                n3_yi   = YI_W'(r_power >> FRAC_BITS);
                n3_yf   = r_power[FRAC_BITS-1:0];
            end
            POL_DECAY: begin
                n3_direct = d_quo[31:0];
            end
            POL_POLY: begin
                n3_pen   = 1'b1;
                n3_x     = n3_over ? 64'd0 : 64'(d_quo);
                n3_xfrac = 6'd32;
                n3_yi    = YI_W'(r_power >> FRAC_BITS);
                n3_yf    = r_power[FRAC_BITS-1:0];
                n3_sat0  = n3_over;
            end
            default: begin
                n3_direct = r_base;
            end
        endcase
    end

    logic            r3_v;
    logic [63:0]     r3_x;
    logic [5:0]      r3_xfrac;
    logic            r3_negy;
    logic [YI_W-1:0] r3_yi;
    logic [YF_W-1:0] r3_yf;
    logic [PT_W-1:0] r3_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= d_v;
        end
        r3_x     <= n3_x;
        r3_xfrac <= n3_xfrac;
        r3_negy  <= n3_negy;
        r3_yi    <= n3_yi;
        r3_yf    <= n3_yf;
        r3_tag   <= {n3_pen, n3_sat0, n3_direct};
    end

    logic            p_v;
    logic [31:0]     p_rate;
    logic            p_sat;
    logic [PT_W-1:0] p_tag;

    lrs_pow #(
        .YI_W  (YI_W),
        .YF_W  (YF_W),
        .TAG_W (PT_W)
    ) u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (r3_v),
        .i_x     (r3_x),
        .i_xfrac (r3_xfrac),
        .i_negy  (r3_negy),
        .i_yi    (r3_yi),
        .i_yf    (r3_yf),
        .i_base  (r_base),
        .i_tag   (r3_tag),
        .o_v     (p_v),
        .o_rate  (p_rate),
        .o_sat   (p_sat),
        .o_tag   (p_tag)
    );

    // ---------------- output register: pick power or direct result
    logic        r_ov;
    logic [31:0] r_rate;
    logic        r_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= p_v;
        end
        r_rate  <= p_tag[33] ? p_rate : p_tag[31:0];
        r_clamp <= p_tag[33] ? (p_tag[32] | p_sat) : 1'b0;
    end

    assign o_valid    = r_ov;
    assign o_rate_out = r_rate;
    assign o_clamped  = r_clamp;

endmodule

FILE: rtl/core/lrs_div.sv
// Restoring divider, one quotient bit per register stage
module lrs_div
    import lrs_pkg::*;
#(
    parameter int Q_W   = 33,
    parameter int TAG_W = 8
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_v,
    input  logic [63:0]      i_num,
    input  logic [63:0]      i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_v,
    output logic [Q_W-1:0]   o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic             s_v   [Q_W+1];
    logic [63:0]      s_rem [Q_W+1];
    logic [63:0]      s_den [Q_W+1];
    logic [Q_W-1:0]   s_quo [Q_W+1];
    logic [TAG_W-1:0] s_tag [Q_W+1];

    assign s_v[0]   = i_v;
    assign s_rem[0] = i_num;
    assign s_den[0] = i_den;
    assign s_quo[0] = '0;
    assign s_tag[0] = i_tag;

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        localparam int B = Q_W - 1 - g;
        logic             r_v;
        logic [63:0]      r_rem;
        logic [63:0]      r_den;
        logic [Q_W-1:0]   r_quo;
        logic [TAG_W-1:0] r_tag;
        logic             n_ge;
        logic [63:0]      n_rem;

        // Try to subtract the divisor at this bit weight
        always_comb begin
            n_ge  = (s_rem[g] >> B) >= s_den[g];
            n_rem = n_ge ? (s_rem[g] - (s_den[g] << B)) : s_rem[g];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= s_v[g];
            end
            r_rem <= n_rem;
            r_den <= s_den[g];
            r_quo <= {s_quo[g][Q_W-2:0], n_ge};
            r_tag <= s_tag[g];
        end

        assign s_v[g+1]   = r_v;
        assign s_rem[g+1] = r_rem;
        assign s_den[g+1] = r_den;
        assign s_quo[g+1] = r_quo;
        assign s_tag[g+1] = r_tag;
    end

    assign o_v   = s_v[Q_W];
    assign o_quo = s_quo[Q_W];
    assign o_tag = s_tag[Q_W];

endmodule

FILE: rtl/core/lrs_pow.sv
// base * x^(+-y) as 2^(y*log2 x): log2 by squaring, capped multiply, exp2 by table
module lrs_pow
    import lrs_pkg::*;
#(
    parameter int YI_W  = 24,
    parameter int YF_W  = 28,
    parameter int TAG_W = 8
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_v,
    input  logic [63:0]      i_x,
    input  logic [5:0]       i_xfrac,
    input  logic             i_negy,
    input  logic [YI_W-1:0]  i_yi,
    input  logic [YF_W-1:0]  i_yf,
    input  logic [31:0]      i_base,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_v,
    output logic [31:0]      o_rate,
    output logic             o_sat,
    output logic [TAG_W-1:0] o_tag
);

    localparam int P1_W = 40 + YI_W;
    localparam int HI_W = 24 + YF_W;
    localparam logic [40:0] T_CAP = 41'd1 << 40;

    typedef struct packed {
        logic             spec;
        logic [31:0]      spec_val;
        logic             spec_sat;
        logic [TAG_W-1:0] tag;
    } t_side;

    typedef struct packed {
        logic            negy;
        logic [YI_W-1:0] yi;
        logic [YF_W-1:0] yf;
        logic [7:0]      e;
        t_side           side;
    } t_lctx;

    // ---------------- S0: register inputs, resolve trivial cases
    t_side n0_side;
    logic  n0_zexp;

    always_comb begin
        n0_zexp           = (i_yi == '0) && (i_yf == '0);
        n0_side.tag       = i_tag;
        n0_side.spec      = n0_zexp || (i_base == '0) || (i_x == '0);
        n0_side.spec_sat  = !n0_zexp && (i_base != '0) && i_negy;
        if (n0_zexp) begin
            n0_side.spec_val = i_base;
        end else if (i_base == '0) begin
            n0_side.spec_val = '0;
        end else begin
            n0_side.spec_val = i_negy ? 32'hFFFF_FFFF : 32'd0;
        end
    end

    logic            r0_v;
    logic [63:0]     r0_x;
    logic [5:0]      r0_xfrac;
    logic            r0_negy;
    logic [YI_W-1:0] r0_yi;
    logic [YF_W-1:0] r0_yf;
    t_side           r0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= i_v;
        end
        r0_x     <= i_x;
        r0_xfrac <= i_xfrac;
        r0_negy  <= i_negy;
        r0_yi    <= i_yi;
        r0_yf    <= i_yf;
        r0_side  <= n0_side;
    end

    // ---------------- S1: find the leading one
    logic [5:0] n1_p;

    always_comb begin
        n1_p = '0;
        for (int i = 0; i < 64; i++) begin
            if (r0_x[i]) n1_p = 6'(i);
        end
    end

    logic        r1_v;
    logic [63:0] r1_x;
    logic [5:0]  r1_p;
    t_lctx       r1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
        r1_x      <= r0_x;
        r1_p      <= n1_p;
        r1_c.negy <= r0_negy;
        r1_c.yi   <= r0_yi;
        r1_c.yf   <= r0_yf;
        r1_c.e    <= 8'(n1_p) - 8'(r0_xfrac);
        r1_c.side <= r0_side;
    end

    // ---------------- S2: normalize to Q1.31
    logic [63:0] n2_sh;

    always_comb begin
        if (r1_p >= 6'd31) begin
            n2_sh = r1_x >> (r1_p - 6'd31);
        end else begin
            n2_sh = r1_x << (6'd31 - r1_p);
        end
    end

    logic        s_lv [33];
    logic [31:0] s_lm [33];
    logic [31:0] s_lf [33];
    t_lctx       s_lc [33];

    logic        r2_v;
    logic [31:0] r2_m;
    t_lctx       r2_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_m <= n2_sh[31:0];
        r2_c <= r1_c;
    end

    assign s_lv[0] = r2_v;
    assign s_lm[0] = r2_m;
    assign s_lf[0] = '0;
    assign s_lc[0] = r2_c;

    // ---------------- L: one fraction bit of log2 per stage by squaring
    for (genvar g = 0; g < 32; g++) begin : g_log
        logic        r_v;
        logic [31:0] r_m;
        logic [31:0] r_f;
        t_lctx       r_c;
        logic [63:0] n_sq;
        logic [31:0] n_m;
        logic        n_bit;

        always_comb begin
            n_sq  = 64'(s_lm[g]) * 64'(s_lm[g]);
            n_bit = n_sq[63];
            n_m   = n_bit ? n_sq[63:32] : n_sq[62:31];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= s_lv[g];
            end
            r_m <= n_m;
            r_f <= {s_lf[g][30:0], n_bit};
            r_c <= s_lc[g];
        end

        assign s_lv[g+1] = r_v;
        assign s_lm[g+1] = r_m;
        assign s_lf[g+1] = r_f;
        assign s_lc[g+1] = r_c;
    end

    // ---------------- S3: magnitude and sign of log2
    t_lctx       c3;
    logic [39:0] n3_val;
    logic        n3_neg;

    always_comb begin
        c3     = s_lc[32];
        n3_val = {c3.e, s_lf[32]};
        n3_neg = c3.e[7];
    end

    logic            r3_v;
    logic [39:0]     r3_a;
    logic            r3_neg;
    logic            r3_negy;
    logic [YI_W-1:0] r3_yi;
    logic [YF_W-1:0] r3_yf;
    t_side           r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= s_lv[32];
        end
        r3_a    <= n3_neg ? (~n3_val + 40'd1) : n3_val;
        r3_neg  <= n3_neg;
        r3_negy <= c3.negy;
        r3_yi   <= c3.yi;
        r3_yf   <= c3.yf;
        r3_side <= c3.side;
    end

    // ---------------- M1: partial products of a * y
    logic                 rm1_v;
    logic [20+YI_W-1:0]   rm1_ph;
    logic [20+YI_W-1:0]   rm1_pl;
    logic [HI_W-1:0]      rm1_hi;
    logic [16+YF_W-1:0]   rm1_lo;
    logic                 rm1_neg;
    t_side                rm1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm1_v <= 1'b0;
        end else begin
            rm1_v <= r3_v;
        end
        rm1_ph   <= (20+YI_W)'(r3_a[39:20]) * (20+YI_W)'(r3_yi);
        rm1_pl   <= (20+YI_W)'(r3_a[19:0]) * (20+YI_W)'(r3_yi);
        rm1_hi   <= HI_W'(r3_a[39:16]) * HI_W'(r3_yf);
        rm1_lo   <= (16+YF_W)'(r3_a[15:0]) * (16+YF_W)'(r3_yf);
        rm1_neg  <= r3_neg ^ r3_negy;
        rm1_side <= r3_side;
    end

    // ---------------- M2: integer and fraction products
    logic [HI_W:0] n2_p2s;

    always_comb begin
        n2_p2s = (HI_W+1)'(rm1_hi) + (HI_W+1)'(rm1_lo >> 16);
    end

    logic            rm2_v;
    logic [P1_W-1:0] rm2_p1;
    logic [HI_W:0]   rm2_p2;
    logic            rm2_neg;
    t_side           rm2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm2_v <= 1'b0;
        end else begin
            rm2_v <= rm1_v;
        end
        rm2_p1   <= (P1_W'(rm1_ph) << 20) + P1_W'(rm1_pl);
        rm2_p2   <= n2_p2s >> (YF_W - 16);
        rm2_neg  <= rm1_neg;
        rm2_side <= rm1_side;
    end

    // ---------------- M3: sum and cap at 256.0
    logic [P1_W:0] n3_sum;

    always_comb begin
        n3_sum = (P1_W+1)'(rm2_p1) + (P1_W+1)'(rm2_p2);
    end

    logic        rm3_v;
    logic [40:0] rm3_mag;
    logic        rm3_neg;
    t_side       rm3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm3_v <= 1'b0;
        end else begin
            rm3_v <= rm2_v;
        end
        rm3_mag  <= (n3_sum > (P1_W+1)'(T_CAP)) ? T_CAP : n3_sum[40:0];
        rm3_neg  <= rm2_neg;
        rm3_side <= rm2_side;
    end

    // ---------------- M4: split into floor and fraction
    logic [31:0] n4_f0;
    logic [9:0]  n4_mk;

    always_comb begin
        n4_f0 = rm3_mag[31:0];
        n4_mk = 10'(rm3_mag[40:32]);
    end

    logic        s_ev [33];
    logic [31:0] s_em [33];
    logic [31:0] s_ef [33];
    logic [9:0]  s_ek [33];
    t_side       s_es [33];

    logic        rm4_v;
    logic [31:0] rm4_f;
    logic [9:0]  rm4_k;
    t_side       rm4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm4_v <= 1'b0;
        end else begin
            rm4_v <= rm3_v;
        end
        if (rm3_neg) begin
            rm4_k <= (~n4_mk + 10'd1) - 10'(|n4_f0);
            rm4_f <= ~n4_f0 + 32'd1;
        end else begin
            rm4_k <= n4_mk;
            rm4_f <= n4_f0;
        end
        rm4_side <= rm3_side;
    end

    assign s_ev[0] = rm4_v;
    assign s_em[0] = 32'h8000_0000;
    assign s_ef[0] = rm4_f;
    assign s_ek[0] = rm4_k;
    assign s_es[0] = rm4_side;

    // ---------------- E: 2^fraction, one table entry per stage
    for (genvar g = 0; g < 32; g++) begin : g_exp
        localparam logic [31:0] ROOT = root_entry(g + 1);
        logic        r_v;
        logic [31:0] r_m;
        logic [31:0] r_f;
        logic [9:0]  r_k;
        t_side       r_s;
        logic [63:0] n_pr;

        always_comb begin
            n_pr = 64'(s_em[g]) * 64'(ROOT);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= s_ev[g];
            end
            r_m <= s_ef[g][31-g] ? n_pr[62:31] : s_em[g];
            r_f <= s_ef[g];
            r_k <= s_ek[g];
            r_s <= s_es[g];
        end

        assign s_ev[g+1] = r_v;
        assign s_em[g+1] = r_m;
        assign s_ef[g+1] = r_f;
        assign s_ek[g+1] = r_k;
        assign s_es[g+1] = r_s;
    end

    // ---------------- F1: scale the base
    logic        rf1_v;
    logic [63:0] rf1_prod;
    logic [9:0]  rf1_k;
    t_side       rf1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf1_v <= 1'b0;
        end else begin
            rf1_v <= s_ev[32];
        end
        rf1_prod <= 64'(i_base) * 64'(s_em[32]);
        rf1_k    <= s_ek[32];
        rf1_side <= s_es[32];
    end

    // ---------------- F2: apply 2^floor, saturate, pick trivial cases
    logic signed [10:0] n5_sh;
    logic        [10:0] n5_ls;
    logic        [63:0] n5_r;
    logic        [31:0] n5_rate;
    logic               n5_sat;

    always_comb begin
        n5_sh   = 11'sd31 - $signed({rf1_k[9], rf1_k});
        n5_ls   = 11'(-n5_sh);
        n5_r    = '0;
        n5_rate = '0;
        n5_sat  = 1'b0;
        if (n5_sh >= 11'sd64) begin
            n5_rate = '0;
        end else if (n5_sh >= 11'sd0) begin
            n5_r    = rf1_prod >> n5_sh[5:0];
            n5_sat  = |n5_r[63:32];
            n5_rate = n5_sat ? 32'hFFFF_FFFF : n5_r[31:0];
        end else if ((n5_ls >= 11'd32) ||
                     (rf1_prod > (64'hFFFF_FFFF >> n5_ls[4:0]))) begin
            n5_sat  = 1'b1;
            n5_rate = 32'hFFFF_FFFF;
        end else begin
            n5_r    = rf1_prod << n5_ls[4:0];
            n5_rate = n5_r[31:0];
        end
        if (rf1_side.spec) begin
            n5_rate = rf1_side.spec_val;
            n5_sat  = rf1_side.spec_sat;
        end
    end

    logic             rf2_v;
    logic [31:0]      rf2_rate;
    logic             rf2_sat;
    logic [TAG_W-1:0] rf2_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf2_v <= 1'b0;
        end else begin
            rf2_v <= rf1_v;
        end
        rf2_rate <= n5_rate;
        rf2_sat  <= n5_sat;
        rf2_tag  <= rf1_side.tag;
    end

    assign o_v    = rf2_v;
    assign o_rate = rf2_rate;
    assign o_sat  = rf2_sat;
    assign o_tag  = rf2_tag;

endmodule

FILE: rtl/core/lrs_chk.sv
// Port-level checks on transaction timing and result fields
module lrs_chk
    import lrs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [31:0] o_rate_out,
    input logic        o_clamped
);

    // Every accepted transaction yields a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LRS_LATENCY o_valid)
        else $error("accepted transaction produced no result");

    // No result without a transaction accepted the latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LRS_LATENCY))
        else $error("result without matching transaction");

    // Reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

    // Result fields carry known values while the strobe is high
    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_rate_out, o_clamped}))
        else $error("result fields unknown under strobe");

endmodule

bind learning_rate_schedule lrs_chk u_lrs_chk (.*);

FILE: verif/learning_rate_schedule_test.sv
module learning_rate_schedule_test;
    import lrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
    localparam logic [63:0] T_CAP   = 64'd1 << 40;
    localparam logic [63:0] OUT_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] rate;
        logic        clamped;
    } t_rate_res;

    typedef struct {
        logic [2:0]  policy;
        logic [31:0] base;
        logic [31:0] gamma;
        logic [31:0] power;
        logic [23:0] step_len;
        logic [31:0] decay;
        logic [23:0] final_it;
    } t_sched_cfg;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [23:0] i_iteration;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic [31:0] o_rate_out;
    logic        o_clamped;

    t_sched_cfg  sched;
    t_rate_res   rate_q[$];
    logic [63:0] sqrt2_pow[33];
    int          mismatches;
    bit          gaps_on;

    learning_rate_schedule u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_iteration (i_iteration),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_rate_out  (o_rate_out),
        .o_clamped   (o_clamped)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Integer square root, bit by bit
    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 of a nonzero value with xfrac fraction bits, signed Q.32
    function automatic longint log2_fix(input logic [63:0] x, input int xfrac);
        int          p;
        logic [63:0] m;
        logic [63:0] frac;
        p    = 63;
        frac = '0;
        while (x[p] == 1'b0) p--;
        m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
        for (int i = 0; i < 32; i++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= ONE_Q32) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return longint'(p - xfrac) * longint'(ONE_Q32) + longint'(frac);
    endfunction

    // Magnitude times yi + yf/2^28, capped
    function automatic logic [63:0] scale_mag(input logic [63:0] a, input logic [63:0] yi,
                                              input logic [63:0] yf);
        logic [63:0] p1;
        logic [63:0] p2;
        logic [63:0] hi;
        logic [63:0] lo;
        if (yi != 0 && a > T_CAP / yi) return T_CAP;
        p1 = a * yi;
        hi = (a >> 16) * yf;
        lo = (a & 64'hFFFF) * yf;
        p2 = (hi + (lo >> 16)) >> 12;
        p1 = p1 + p2;
        return (p1 > T_CAP) ? T_CAP : p1;
    endfunction

    // base * x^(+-y) through exp2(y*log2 x)
    function automatic logic [63:0] pow_rate(input logic [63:0] base, input logic [63:0] x,
                                             input int xfrac, input bit negy,
                                             input logic [63:0] yi, input logic [63:0] yf,
                                             inout bit sat);
        longint      lg;
        longint      k;
        logic [63:0] a;
        logic [63:0] mag;
        logic [63:0] f;
        logic [63:0] m;
        logic [63:0] prod;
        logic [63:0] r;
        bit          neg;
        int          shift;
        int          ls;
        if (yi == 0 && yf == 0) return base;
        if (base == 0) return 0;
        if (x == 0) begin
            if (!negy) return 0;
            sat = 1'b1;
            return OUT_MAX;
        end
        lg  = log2_fix(x, xfrac);
        neg = (lg < 0);
        a   = neg ? -lg : lg;
        mag = scale_mag(a, yi, yf);
        if (negy) neg = !neg;
        k = longint'(mag >> 32);
        f = mag & (ONE_Q32 - 1);
        if (neg) begin
            k = -k;
            if (f != 0) begin
                k = k - 1;
                f = ONE_Q32 - f;
            end
        end
        m = 64'd1 << 31;
        for (int i = 1; i <= 32; i++) begin
            if (f[32 - i]) m = (m * sqrt2_pow[i]) >> 31;
        end
        prod  = base * m;
        shift = 31 - int'(k);
        if (shift >= 64) return 0;
        if (shift >= 0) begin
            r = prod >> shift;
        end else begin
            ls = -shift;
            if (ls >= 32 || prod > (OUT_MAX >> ls)) begin
                sat = 1'b1;
                return OUT_MAX;
            end
            r = prod << ls;
        end
        if (r > OUT_MAX) begin
            sat = 1'b1;
            return OUT_MAX;
        end
        return r;
    endfunction

    // Expected rate for one iteration under the current schedule
    function automatic t_rate_res calc_rate(input logic [23:0] it);
        t_rate_res   res;
        logic [63:0] rate;
        logic [63:0] x;
        logic [63:0] d;
        bit          sat;
        sat  = 1'b0;
        rate = sched.base;
        case (sched.policy)
            POL_STEP: begin
                d    = (sched.step_len == 0) ? 64'd1 : 64'(sched.step_len);
                rate = pow_rate(sched.base, sched.gamma, 28, 1'b0, 64'(it) / d, 0, sat);
            end
            POL_EXP: begin
                rate = pow_rate(sched.base, sched.gamma, 28, 1'b0, 64'(it), 0, sat);
            end
            POL_INV: begin
                x = 64'(sched.gamma) * 64'(it);
                x = (x > 64'hFFFF_FFFF_FFFF_FFFF - (64'd1 << 28)) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                                 : x + (64'd1 << 28);
                rate = pow_rate(sched.base, x, 28, 1'b1, 64'(sched.power >> 28),
                                64'(sched.power[27:0]), sat);
            end
            POL_DECAY: begin
                x    = 64'(it) * 64'(sched.decay);
                x    = (x > 64'hFFFF_FFFF_FFFF_FFFF - ONE_Q32) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                               : x + ONE_Q32;
                rate = (64'(sched.base) << 32) / x;
            end
            POL_POLY: begin
                d = (sched.final_it == 0) ? 64'd1 : 64'(sched.final_it);
                if (64'(it) > d) begin
                    x   = 0;
                    sat = 1'b1;
                end else begin
                    x = ((d - 64'(it)) << 32) / d;
                end
                rate = pow_rate(sched.base, x, 32, 1'b0, 64'(sched.power >> 28),
                                64'(sched.power[27:0]), sat);
            end
            default: rate = sched.base;
        endcase
        res.rate    = rate[31:0];
        res.clamped = sat;
        return res;
    endfunction

    // Compare each result against the oldest expected rate
    always @(posedge i_clk) begin
        t_rate_res want;
        if (i_rst_n && o_valid) begin
            if (rate_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result rate=%h clamped=%b",
                                               o_rate_out, o_clamped);
            end else begin
                want = rate_q.pop_front();
                if (o_rate_out !== want.rate || o_clamped !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("rate mismatch: expected %h/%b got %h/%b",
                                 want.rate, want.clamped, o_rate_out, o_clamped);
                end
            end
        end
    end

    // Offer one iteration, with a random gap first
    task automatic send_iter(input logic [23:0] it);
        while (gaps_on && $urandom_range(99) < 16) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_iteration <= it;
        do @(posedge i_clk); while (busy);
        rate_q.push_back(calc_rate(it));
    endtask

    // Hold the sender until every expected rate has arrived
    task automatic drain();
        start <= 1'b0;
        while (rate_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all registers in one burst of transactions
    task automatic load_sched(input t_sched_cfg c);
        logic [31:0] vals[7];
        drain();
        vals = '{32'(c.policy), c.base, c.gamma, c.power, 32'(c.step_len),
                 c.decay, 32'(c.final_it)};
        for (int i = REG_POLICY; i <= REG_FINAL; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        sched = c;
    endtask

    function automatic t_sched_cfg default_sched();
        t_sched_cfg c;
        c.policy   = RST_POLICY;
        c.base     = RST_BASE;
        c.gamma    = RST_GAMMA;
        c.power    = RST_POWER;
        c.step_len = RST_STEP[23:0];
        c.decay    = RST_DECAY;
        c.final_it = RST_FINAL[23:0];
        return c;
    endfunction

    function automatic logic [31:0] pick32(input logic [31:0] typical);
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return typical;
        endcase
    endfunction

    function automatic logic [23:0] pick_iter(input logic [23:0] pivot);
        case ($urandom_range(9))
            0:       return 24'd0;
            1:       return 24'hFF_FFFF;
            2, 3:    return 24'($urandom);
            4, 5:    return pivot + 24'($urandom_range(4)) - 24'd2;
            6:       return 24'($urandom_range(300));
            default: return 24'($urandom_range(int'(pivot) * 2 + 1));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_iter(24'd0);
        send_iter(24'hFF_FFFF);
        send_iter(24'd100000);
    endtask

    task automatic test_directed();
        t_sched_cfg c;
        c = default_sched();
        // fixed, zero base, and the unused codes
        c.policy = POL_FIXED; c.base = 32'hFFFF_FFFF; load_sched(c);
        send_iter(24'd5);
        c.policy = 3'd6; c.base = 32'd0; load_sched(c);
        send_iter(24'hFF_FFFF);
        c.policy = 3'd7; c.base = 32'h1234_5678; load_sched(c);
        send_iter(24'd1);
        // step: zero length acts as one, exponent zero below the first step
        c.policy = POL_STEP; c.gamma = 32'h1800_0000; c.step_len = 24'd0; load_sched(c);
        send_iter(24'd3);
        send_iter(24'hFF_FFFF);
        c.step_len = 24'hFF_FFFF; load_sched(c);
        send_iter(24'hFF_FFFE);
        // exp: zero gamma, saturation on a large gamma
        c.policy = POL_EXP; c.gamma = 32'd0; load_sched(c);
        send_iter(24'd0);
        send_iter(24'd7);
        c.gamma = 32'hFFFF_FFFF; c.base = 32'hFFFF_FFFF; load_sched(c);
        send_iter(24'd40);
        // inv: zero power and the largest operands
        c.policy = POL_INV; c.power = 32'd0; load_sched(c);
        send_iter(24'd9);
        c.power = 32'hFFFF_FFFF; c.gamma = 32'hFFFF_FFFF; load_sched(c);
        send_iter(24'hFF_FFFF);
        send_iter(24'd0);
        // decay at both ends
        c.policy = POL_DECAY; c.decay = 32'hFFFF_FFFF; load_sched(c);
        send_iter(24'hFF_FFFF);
        send_iter(24'd0);
        // poly: zero final, past the final iteration, zero power
        c.policy = POL_POLY; c.final_it = 24'd0; c.power = 32'h2000_0000; load_sched(c);
        send_iter(24'd0);
        send_iter(24'd1);
        send_iter(24'd2);
        c.final_it = 24'hFF_FFFF; load_sched(c);
        send_iter(24'hFF_FFFF);
        send_iter(24'd12345);
        c.final_it = 24'd50; c.power = 32'd0; load_sched(c);
        send_iter(24'd51);
    endtask

    task automatic test_random_phases();
        t_sched_cfg c;
        logic [23:0] pivot;
        for (int ph = 0; ph < 11; ph++) begin
            c.policy   = (ph < 6) ? 3'(ph) : 3'($urandom_range(7));
            c.base     = pick32(32'($urandom_range(32'h3000_0000)));
            c.gamma    = pick32(32'h0C00_0000 + 32'($urandom_range(32'h0800_0000)));
            c.power    = pick32(32'($urandom_range(32'h4000_0000)));
            c.step_len = ($urandom_range(4) == 0) ? 24'hFF_FFFF : 24'($urandom_range(2000, 1));
            c.decay    = pick32(32'($urandom_range(32'h0010_0000)));
            c.final_it = ($urandom_range(4) == 0) ? 24'hFF_FFFF : 24'($urandom_range(5000, 1));
            load_sched(c);
            pivot   = (c.policy == POL_STEP) ? c.step_len
                    : (c.policy == POL_EXP)  ? 24'd64 : c.final_it;
            gaps_on = (ph != 3);
            for (int n = 0; n < 100; n++) begin
                send_iter(pick_iter(pivot));
                if (ph == 5 && n == 50) drain();
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        logic [63:0] v;
        v            = ONE_Q32;
        sqrt2_pow[0] = v;
        for (int i = 1; i <= 32; i++) begin
            v            = int_sqrt(v << 31);
            sqrt2_pow[i] = v;
        end
        sched       = default_sched();
        mismatches  = 0;
        gaps_on     = 1'b1;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_iteration = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_POLICY;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed();
        test_random_phases();

        drain();
        repeat (LRS_LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && rate_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
